/* sv/ldd_pkg.sv */
// Shared types and constants for the line deframer with drop-oldest overflow.
// No dependencies; imported by every module of the block.
package ldd_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int MAX_SEGMENT  = 32;

  localparam int PTR_W  = $clog2(BUFFER_BYTES);
  localparam int CNT_W  = PTR_W + 1;
  localparam int SEG_W  = $clog2(MAX_SEGMENT + 1);
  localparam int CAP_W  = 7;
  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int ERR_W  = 32;

  localparam logic [BYTE_W-1:0] LINE_FEED = 8'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_MARK
  } ldd_state_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic load_byte;
    logic load_mark;
  } ldd_cmd_t;

  typedef struct packed {
    logic emit;
    logic emit_empty;
    logic last_byte;
    logic out_free;
  } ldd_sts_t;

endpackage

/* sv/ldd_dp.sv */
// Datapath: buffer pointers, chunk/drop bookkeeping, line store and result register.
// Depends on ldd_pkg; driven by commands from ldd_ctrl.
module ldd_dp import ldd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CAP_W-1:0]  capacity,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [LEN_W-1:0]  in_chunk_length,
  input  logic              in_first_of_chunk,
  input  ldd_cmd_t          cmd,
  output ldd_sts_t          sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_line_byte,
  output logic              out_byte_valid,
  output logic              out_segment_end,
  output logic              out_line_end,
  output logic [ERR_W-1:0]  out_overflow_count
);

  logic [BYTE_W-1:0] mem [BUFFER_BYTES];

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [LEN_W-1:0] skip_r, skip_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;

  logic [PTR_W-1:0]  emit_head_r;
  logic [CNT_W-1:0]  emit_len_r;
  logic [CNT_W-1:0]  idx_r;
  logic [SEG_W-1:0]  seg_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              out_valid_r;

  logic             cap_zero;
  logic [CNT_W-1:0] cap_c, held0, space, drop_n, held1;
  logic [PTR_W-1:0] head0, head1;
  logic [LEN_W-1:0] len_c, skip1;
  logic             do_start, over, big, skipping, is_lf, store, long_line;
  logic [CNT_W-1:0] idx_inc;
  logic             seg_wrap, last_byte;

  always_comb begin
    cap_zero = (capacity == '0);
    cap_c = (capacity > CAP_W'(BUFFER_BYTES)) ? CNT_W'(BUFFER_BYTES) : CNT_W'(capacity);
    held0 = (held_r > cap_c) ? '0 : held_r;
    head0 = (held_r > cap_c) ? '0 : head_r;
    do_start = in_first_of_chunk || ((skip_r == '0) && (held0 >= cap_c));
    if (!in_first_of_chunk) begin
      len_c = LEN_W'(1);
    end else if (in_chunk_length == '0) begin
      len_c = LEN_W'(1);
    end else begin
      len_c = in_chunk_length;
    end
    space  = cap_c - held0;
    over   = do_start && (len_c > LEN_W'(space));
    big    = len_c > LEN_W'(cap_c);
    drop_n = big ? held0 : CNT_W'(len_c - LEN_W'(space));
    head1  = head0;
    held1  = held0;
    skip1  = skip_r;
    if (over) begin
      head1 = head0 + drop_n[PTR_W-1:0];
      held1 = held0 - drop_n;
      skip1 = big ? (len_c - LEN_W'(cap_c)) : '0;
    end else if (do_start) begin
      skip1 = '0;
    end
    skipping  = (skip1 != '0);
    is_lf     = (in_data_byte == LINE_FEED);
    sts.emit  = !cap_zero && !skipping && is_lf;
    store     = !cap_zero && !skipping && !is_lf && (held1 < cap_c);
    long_line = 8'(held1) > 8'(MAX_SEGMENT);
    sts.emit_empty = (held1 == '0);

    idx_inc   = idx_r + CNT_W'(1);
    last_byte = (idx_inc == emit_len_r);
    seg_wrap  = (seg_r == SEG_W'(MAX_SEGMENT - 1));
    sts.last_byte = last_byte;
    sts.out_free  = !out_valid_r || out_ready;

    head_nxt = head_r;
    held_nxt = held_r;
    skip_nxt = skip_r;
    err_nxt  = err_r;
    if (cmd.accept && !cap_zero) begin
      head_nxt = sts.emit ? (head1 + held1[PTR_W-1:0]) : head1;
      if (sts.emit) begin
        held_nxt = '0;
      end else if (store) begin
        held_nxt = held1 + CNT_W'(1);
      end else begin
        held_nxt = held1;
      end
      skip_nxt = skipping ? (skip1 - LEN_W'(1)) : skip1;
      err_nxt  = err_r + ERR_W'(over) + ERR_W'(sts.emit && long_line);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      held_r      <= '0;
      skip_r      <= '0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      held_r <= held_nxt;
      skip_r <= skip_nxt;
      err_r  <= err_nxt;
      if (cmd.load_byte || cmd.load_mark) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line store: written on stored bytes, read one byte per drain step
  always_ff @(posedge clk) begin
    if (cmd.accept && store) begin
      mem[head1 + held1[PTR_W-1:0]] <= in_data_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[emit_head_r + idx_r[PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.emit) begin
      emit_head_r <= head1;
      emit_len_r  <= held1;
      idx_r       <= '0;
      seg_r       <= '0;
    end else if (cmd.load_byte) begin
      idx_r <= idx_inc;
      seg_r <= seg_wrap ? '0 : seg_r + SEG_W'(1);
    end
    if (cmd.load_byte) begin
      out_line_byte      <= rd_data_r;
      out_byte_valid     <= 1'b1;
      out_segment_end    <= last_byte || seg_wrap;
      out_line_end       <= last_byte;
      out_overflow_count <= err_r;
    end else if (cmd.load_mark) begin
      out_line_byte      <= '0;
      out_byte_valid     <= 1'b0;
      out_segment_end    <= 1'b1;
      out_line_end       <= 1'b1;
      out_overflow_count <= err_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/ldd_ctrl.sv */
// Controller: sequences item acceptance and the byte-by-byte drain of a held line.
// Depends on ldd_pkg; commands ldd_dp.
module ldd_ctrl import ldd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ldd_sts_t sts,
  output ldd_cmd_t cmd
);

  ldd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.emit) begin
          state_nxt = sts.emit_empty ? ST_MARK : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (sts.out_free) begin
          cmd.load_byte = 1'b1;
          state_nxt     = sts.last_byte ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_MARK: begin
        if (sts.out_free) begin
          cmd.load_mark = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* sv/line_deframer_drop_oldest_unit.sv */
// Top level: line deframer with drop-oldest overflow, APB capacity register.
// Depends on ldd_pkg, ldd_ctrl and ldd_dp.
//
//   channel  | handshake             | payload
//   input    | in_valid / in_ready   | in_data_byte, in_chunk_length, in_first_of_chunk
//   result   | out_valid / out_ready | out_line_byte, out_byte_valid, out_segment_end,
//            |                       | out_line_end, out_overflow_count
//   config   | psel/penable/pwrite   | paddr, pwdata, prdata (capacity at 0x0)
//
// A byte that is not a line feed leaves input open; the next is accepted right after.
// A line feed blocks input while its line drains (one line-store read and one result
// load per byte; just the marker load for an empty line), plus any output stall.
// Synchronous active-low reset clears pointers, counts and errors; capacity -> 64.
module line_deframer_drop_oldest_unit import ldd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [LEN_W-1:0]  in_chunk_length,
  input  logic              in_first_of_chunk,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_line_byte,
  output logic              out_byte_valid,
  output logic              out_segment_end,
  output logic              out_line_end,
  output logic [ERR_W-1:0]  out_overflow_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  ldd_cmd_t         cmd;
  ldd_sts_t         sts;

  assign pready = 1'b1;

  // single register; every byte offset selects it
  always_comb begin
    capacity_nxt = capacity_r;
    if (psel && penable && pwrite) begin
      capacity_nxt = pwdata[CAP_W-1:0];
    end
    prdata = (paddr == 2'b00) ? 32'(capacity_r) : 32'(capacity_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_W'(64);
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  ldd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ldd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .capacity           (capacity_r),
    .in_data_byte       (in_data_byte),
    .in_chunk_length    (in_chunk_length),
    .in_first_of_chunk  (in_first_of_chunk),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_line_byte      (out_line_byte),
    .out_byte_valid     (out_byte_valid),
    .out_segment_end    (out_segment_end),
    .out_line_end       (out_line_end),
    .out_overflow_count (out_overflow_count)
  );

`ifndef SYNTHESIS
  a_marker_closes_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_segment_end && out_line_end)
    else $error("empty-line marker without segment/line end");

  a_line_end_is_seg_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end |-> out_segment_end)
    else $error("line end without segment end");

  a_input_blocked_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid && !out_line_end |-> !in_ready)
    else $error("input accepted while a line is still draining");

  a_one_load_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && (cmd.load_byte || cmd.load_mark || cmd.rd_issue)))
    else $error("accept overlaps drain command");
`endif

endmodule
